// ===== rtl/core/egc_pkg.sv =====
// Shared types and constants for the echo gate and cluster core.
package egc_pkg;

  localparam int TIME_W    = 16;
  localparam int HITS_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 16;

  localparam logic [TIME_W-1:0] RANGE_LO_RST  = 16'd2000;
  localparam logic [TIME_W-1:0] RANGE_HI_RST  = 16'd30000;
  localparam logic [TIME_W-1:0] MAX_GAP_RST   = 16'd30;
  localparam logic [HITS_W-1:0] MIN_HITS_RST  = 10'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LO  = 2'd0,
    CFG_RANGE_HI  = 2'd1,
    CFG_MAX_GAP   = 2'd2,
    CFG_MIN_HITS  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_ECHO = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    logic [TIME_W-1:0] range_lo;
    logic [TIME_W-1:0] range_hi;
    logic [TIME_W-1:0] max_gap;
    logic [HITS_W-1:0] min_hits;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] object_start;
    logic [TIME_W-1:0] object_size;
    logic              at_capture_end;
  } result_t;

endpackage

// ===== rtl/core/egc_in_if.sv =====
// Echo input channel: valid/ready handshake with operation and echo time.
interface egc_in_if import egc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] echo_time;

  modport source (output valid, output operation, output echo_time, input ready);
  modport sink   (input valid, input operation, input echo_time, output ready);
endinterface

// ===== rtl/core/egc_out_if.sv =====
// Object result channel: valid/ready handshake with cluster start, size and flush flag.
interface egc_out_if import egc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] object_start;
  logic [TIME_W-1:0] object_size;
  logic              at_capture_end;

  modport source (output valid, output object_start, output object_size,
                  output at_capture_end, input ready);
  modport sink   (input valid, input object_start, input object_size,
                  input at_capture_end, output ready);
endinterface

// ===== rtl/core/egc_cfg_regs.sv =====
// Configuration register file for range, gap and hit-count limits.
module egc_cfg_regs import egc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE_LO:  cfg_nxt.range_lo  = cfg_wdata[TIME_W-1:0];
        CFG_RANGE_HI:  cfg_nxt.range_hi  = cfg_wdata[TIME_W-1:0];
        CFG_MAX_GAP:   cfg_nxt.max_gap   = cfg_wdata[TIME_W-1:0];
        CFG_MIN_HITS:  cfg_nxt.min_hits  = cfg_wdata[HITS_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_lo  <= RANGE_LO_RST;
      cfg_r.range_hi  <= RANGE_HI_RST;
      cfg_r.max_gap   <= MAX_GAP_RST;
      cfg_r.min_hits  <= MIN_HITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/egc_cluster.sv =====
// Echo gating, capture counting and cluster tracking with object emission.
module egc_cluster import egc_pkg::*; #(
  parameter int MAX_ECHOES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              operation,
  input  logic [TIME_W-1:0] echo_time,
  input  cfg_t              cfg,
  output logic              res_valid,
  output result_t           res
);

  localparam int CNT_W = $clog2(MAX_ECHOES + 1);

  logic [TIME_W-1:0] first_r, first_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              open_cl;
  logic              is_obj;
  logic              full;
  logic              in_rng;
  logic signed [TIME_W+1:0] gap;
  logic              joins;

  assign open_cl = (hits_r != '0);
  assign is_obj  = open_cl && (hits_r >= cfg.min_hits);
  assign full    = (cnt_r >= CNT_W'(MAX_ECHOES));
  assign in_rng  = (echo_time > cfg.range_lo) && (echo_time < cfg.range_hi);
  assign gap     = $signed({2'b00, echo_time}) - $signed({2'b00, prev_r});
  assign joins   = (gap < $signed({2'b00, cfg.max_gap}));

  always_comb begin
    first_nxt          = first_r;
    prev_nxt           = prev_r;
    hits_nxt           = hits_r;
    cnt_nxt            = cnt_r;
    res_valid          = 1'b0;
    res.object_start   = first_r;
    res.object_size    = prev_r - first_r;
    res.at_capture_end = 1'b0;
    if (fire) begin
      if (op_t'(operation) == OP_END) begin
        res_valid          = is_obj;
        res.at_capture_end = 1'b1;
        first_nxt          = '0;
        prev_nxt           = '0;
        hits_nxt           = '0;
        cnt_nxt            = '0;
      end else if (!full && in_rng) begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        prev_nxt = echo_time;
        if (!open_cl) begin
          first_nxt = echo_time;
          hits_nxt  = HITS_W'(1);
        end else if (joins) begin
          if (hits_r != '1) begin
            hits_nxt = hits_r + HITS_W'(1);
          end
        end else begin
          res_valid = is_obj;
          first_nxt = echo_time;
          hits_nxt  = HITS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      prev_r  <= '0;
      hits_r  <= '0;
      cnt_r   <= '0;
    end else begin
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      hits_r  <= hits_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/echo_gate_and_cluster_core.sv =====
// Top level of the echo gate and cluster core: input stage, cluster logic, result register.
//
//   channel  | dir | handshake            | payload
//   in_ch    | in  | valid/ready          | operation, echo_time
//   out_ch   | out | valid/ready          | object_start, object_size, at_capture_end
//   cfg_*    | in  | cfg_we (no stall)    | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ch is ready; a result passes through the input
// register, then the cluster state update into the result register.
// Synchronous active-low reset restores register defaults and clears the cluster state.
// A result waiting on out_ch holds the input register; in_ch keeps accepting while it is free.
module echo_gate_and_cluster_core import egc_pkg::*; #(
  parameter int MAX_ECHOES = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  egc_in_if.sink               in_ch,
  egc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  cfg_t              cfg;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_op_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  logic              slot_free;
  logic              advance;
  logic              in_fire;
  logic              res_valid;
  result_t           res;

  egc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  egc_cluster #(.MAX_ECHOES(MAX_ECHOES)) u_cluster (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .operation (s1_op_r),
    .echo_time (s1_time_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && slot_free;
  assign in_ch.ready = !s1_valid_r || slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = slot_free ? (advance && res_valid) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_ch.operation;
      s1_time_r <= in_ch.echo_time;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.object_start   = out_res_r.object_start;
  assign out_ch.object_size    = out_res_r.object_size;
  assign out_ch.at_capture_end = out_res_r.at_capture_end;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while the input register is blocked");

  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && res_valid))
    else $error("result appeared without an advancing transaction");

  a_flush_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.at_capture_end) |-> (op_t'(s1_op_r) == OP_END))
    else $error("capture-end result from an echo transaction");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the echo gate and cluster core: predicted objects checked on the result channel.
module testbench;
  import egc_pkg::*;

  localparam int ECHO_LIMIT  = 512;
  localparam int SETTLE      = 4;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 45;
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SEND   = 1;
  localparam int IDLE_RECV   = 2;
  localparam int IDLE_BOTH   = 3;

  class object_scoreboard;
    logic [TIME_W-1:0] range_lo, range_hi, max_gap;
    logic [HITS_W-1:0] min_hits;
    logic [TIME_W-1:0] first_t, last_t;
    logic [HITS_W-1:0] hits, taken;
    result_t           expected_objects[$];
    int                mismatches, objects_checked, flush_objects, full_captures;

    function new();
      range_lo  = RANGE_LO_RST;
      range_hi  = RANGE_HI_RST;
      max_gap   = MAX_GAP_RST;
      min_hits  = MIN_HITS_RST;
      clear_capture();
    endfunction

    function void clear_capture();
      first_t = '0;
      last_t  = '0;
      hits    = '0;
      taken   = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DW-1:0] v);
      case (idx)
        CFG_RANGE_LO:  range_lo  = v;
        CFG_RANGE_HI:  range_hi  = v;
        CFG_MAX_GAP:   max_gap   = v;
        CFG_MIN_HITS:  min_hits  = v[HITS_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_cluster(logic at_end);
      result_t obj;
      if (hits == 0 || hits < min_hits) return;
      obj.object_start   = first_t;
      obj.object_size    = last_t - first_t;
      obj.at_capture_end = at_end;
      expected_objects = {expected_objects, obj};
    endfunction

    function void note_transaction(op_t op, logic [TIME_W-1:0] t);
      int now_t, prev_t, gap, limit;
      if (op == OP_END) begin
        close_cluster(1'b1);
        clear_capture();
        return;
      end
      if (taken >= ECHO_LIMIT) return;
      if (!(t > range_lo && t < range_hi)) return;
      taken = taken + 1'b1;
      if (taken == ECHO_LIMIT) full_captures++;
      if (hits == 0) begin
        first_t = t;
        hits    = 1;
      end else begin
        now_t  = t;
        prev_t = last_t;
        limit  = max_gap;
        gap    = now_t - prev_t;
        if (gap < limit) begin
          if (hits != {HITS_W{1'b1}}) hits = hits + 1'b1;
        end else begin
          close_cluster(1'b0);
          first_t = t;
          hits    = 1;
        end
      end
      last_t = t;
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"object mismatch (%s): expected start %0d size %0d end %0b,",
                  " got start %0d size %0d end %0b"},
                 what, want.object_start, want.object_size, want.at_capture_end,
                 got.object_start, got.object_size, got.at_capture_end);
    endfunction

    function void check_object(result_t got);
      result_t want;
      if (expected_objects.size() == 0) begin
        report("none expected", '0, got);
        return;
      end
      want = expected_objects.pop_front();
      objects_checked++;
      if (want.at_capture_end) flush_objects++;
      if (got.object_start !== want.object_start) report("object_start", want, got);
      else if (got.object_size !== want.object_size) report("object_size", want, got);
      else if (got.at_capture_end !== want.at_capture_end) report("at_capture_end", want, got);
    endfunction
  endclass

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_wdata;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   idle_cycles    = 0;
  int                   items_sent     = 0;
  int                   settings_used  = 0;
  result_t              seen_object;
  object_scoreboard     sb;

  egc_in_if  in_ch();
  egc_out_if out_ch();

  echo_gate_and_cluster_core #(.MAX_ECHOES(ECHO_LIMIT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_object.object_start   = out_ch.object_start;
      seen_object.object_size    = out_ch.object_size;
      seen_object.at_capture_end = out_ch.at_capture_end;
      sb.check_object(seen_object);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("[echo_gate_and_cluster_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(op_t op, logic [TIME_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.echo_time <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_transaction(op, t);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(int lo, int hi, int gap, int need);
    write_reg(CFG_RANGE_LO, CFG_DW'(lo));
    write_reg(CFG_RANGE_HI, CFG_DW'(hi));
    write_reg(CFG_MAX_GAP, CFG_DW'(gap));
    write_reg(CFG_MIN_HITS, CFG_DW'(need));
    settings_used++;
  endtask

  // drop valid, wait for every expected object, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_objects.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pressure(int mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default:   begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  function automatic int pick_in_range();
    int lo, hi;
    lo = sb.range_lo;
    hi = sb.range_hi;
    if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 65535);
  endfunction

  // one capture: mostly close echoes, some jumps, falling times and strays, then the end
  task automatic run_capture(int n);
    int t, span, pick;
    span = sb.max_gap + sb.max_gap / 4 + 2;
    if (span > 4000) span = 4000;
    t = pick_in_range();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        t = t + $urandom_range(0, span);
      end else if (pick < 72) begin
        t = pick_in_range();
      end else if (pick < 82) begin
        t = t - $urandom_range(1, 60);
      end else if (pick < 94) begin
        send_item(OP_ECHO, TIME_W'($urandom_range(0, 65535)));
        continue;
      end else begin
        send_item(OP_ECHO, pick[0] ? sb.range_lo : sb.range_hi);
        continue;
      end
      t = t & 32'hFFFF;
      send_item(OP_ECHO, t[TIME_W-1:0]);
    end
    send_item(OP_END, TIME_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int lo, hi, gap, need, start;
    sb               = new();
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_ECHO;
    in_ch.echo_time  = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_RANGE_LO;
    cfg_wdata        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: bounds, field extremes, join, split, falling time, empty flush
    send_item(OP_ECHO, 16'd2000);
    send_item(OP_ECHO, 16'd30000);
    send_item(OP_ECHO, 16'd0);
    send_item(OP_ECHO, 16'hFFFF);
    send_item(OP_ECHO, 16'd2001);
    send_item(OP_ECHO, 16'd2010);
    send_item(OP_ECHO, 16'd2020);
    send_item(OP_ECHO, 16'd2050);
    send_item(OP_ECHO, 16'd2040);
    send_item(OP_ECHO, 16'd29999);
    send_item(OP_END, 16'd0);
    send_item(OP_END, 16'd0);
    send_item(OP_ECHO, 16'd5000);
    send_item(OP_ECHO, 16'd5001);
    send_item(OP_ECHO, 16'd5002);
    send_item(OP_END, 16'hFFFF);

    // widest window, zero gap, zero hit count: wrapped size on a falling time
    settle();
    configure(0, 65535, 0, 0);
    send_item(OP_ECHO, 16'd0);
    send_item(OP_ECHO, 16'hFFFF);
    send_item(OP_ECHO, 16'd1);
    send_item(OP_ECHO, 16'd65534);
    send_item(OP_ECHO, 16'd10);
    send_item(OP_END, 16'd0);
    send_item(OP_END, 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      lo   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 5000);
      hi   = ($urandom_range(0, 9) < 2) ? 65535 : $urandom_range(8000, 65535);
      case ($urandom_range(0, 9))
        0:       gap = 0;
        1:       gap = 65535;
        default: gap = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 9))
        0:       need = 0;
        1:       need = 1;
        default: need = $urandom_range(2, 6);
      endcase
      configure(lo, hi, gap, need);
      set_pressure(p % 4);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          send_item(op_t'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 65535)));
        else
          run_capture($urandom_range(1, 16));
      end
    end

    // fill a capture past the echo limit as one cluster
    settle();
    configure(0, 65535, 65535, ECHO_LIMIT);
    set_pressure(IDLE_BOTH);
    for (int i = 0; i < ECHO_LIMIT + 8; i++)
      send_item(OP_ECHO, TIME_W'($urandom_range(1, 65534)));
    send_item(OP_END, TIME_W'($urandom_range(0, 65535)));

    settle();
    $display("Sent %0d transactions under %0d register settings and four idling patterns.",
             items_sent, settings_used + 1);
    $display("Checked %0d objects (%0d from capture-end flushes); %0d captures hit the echo limit.",
             sb.objects_checked, sb.flush_objects, sb.full_captures);
    if (sb.mismatches == 0 && sb.expected_objects.size() == 0) begin
      $display("[echo_gate_and_cluster_core] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[echo_gate_and_cluster_core] ERROR");
    end
    $finish;
  end

endmodule
